// ===== hw/rtl/h2r_pkg.sv =====
package h2r_pkg;

  // Field widths
  localparam int unsigned HUE_W = 15;
  localparam int unsigned CH_W  = 8;

  // Hue fraction bits below one degree
  localparam int unsigned HUE_FRAC_BITS = 6;

  // Degrees per sector and full-scale code of saturation/value
  localparam int unsigned SEC_BASE   = 60;
  localparam int unsigned FULL_SCALE = 255;

  // Sector split: whole degrees / 60 through a reciprocal, exact below 2^15
  localparam int unsigned DIV60_MUL   = 34953;
  localparam int unsigned DIV60_SHIFT = 21;
  localparam int unsigned PROD_W      = HUE_W + 16;
  localparam int unsigned QUOT_W      = 10;
  localparam int unsigned REM60_W     = 6;

  // Level divide: numerator / 3825 after dropping (frac bits + 2) low bits
  localparam int unsigned LVL_NUM_W     = 20;
  localparam int unsigned LVL_DIV       = 3825;
  localparam int unsigned LVL_RCP       = 4386;
  localparam int unsigned LVL_RCP_SHIFT = 24;
  localparam int unsigned LVL_PROD_W    = 33;

  localparam int unsigned SEC_W = 3;

  typedef enum logic [SEC_W-1:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } h2r_sector_e;

  // Advance strobes for the five stages of a level unit
  typedef struct packed {
    logic sy;
    logic diff;
    logic scale;
    logic rcp;
    logic fix;
  } h2r_lvl_adv_t;

endpackage

// ===== hw/rtl/h2r_if.sv =====
interface h2r_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [h2r_pkg::HUE_W-1:0]  hue;
  logic [h2r_pkg::CH_W-1:0]   saturation;
  logic [h2r_pkg::CH_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface h2r_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [h2r_pkg::CH_W-1:0]   red;
  logic [h2r_pkg::CH_W-1:0]   green;
  logic [h2r_pkg::CH_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/h2r_level.sv =====
// Five-stage level unit: floor(val * (W - sat * span) / W), W = 255 * sector width.
module h2r_level #(
  parameter int unsigned HueFracBits = h2r_pkg::HUE_FRAC_BITS
) (
  input  logic                        clk_i,
  input  h2r_pkg::h2r_lvl_adv_t       adv_i,
  input  logic [HueFracBits+5:0]      span_i,
  input  logic [h2r_pkg::CH_W-1:0]    sat_i,
  input  logic [h2r_pkg::CH_W-1:0]    val_i,
  output logic [h2r_pkg::CH_W-1:0]    level_o
);

  localparam int unsigned SpanW  = HueFracBits + 6;
  localparam int unsigned FullW  = SpanW + 8;
  localparam int unsigned ScaleW = FullW + 8;
  localparam int unsigned NumW   = h2r_pkg::LVL_NUM_W;
  localparam int unsigned PrdW   = h2r_pkg::LVL_PROD_W;
  localparam int unsigned ChW    = h2r_pkg::CH_W;
  localparam logic [FullW-1:0] Whole =
    FullW'(h2r_pkg::FULL_SCALE * (h2r_pkg::SEC_BASE << HueFracBits));

  logic [FullW-1:0]  sy_q, sy_d;
  logic [FullW-1:0]  diff_q, diff_d;
  logic [ScaleW-1:0] x_q, x_d;
  logic [NumW-1:0]   num_q;
  logic [NumW-1:0]   num_d;
  logic [ChW-1:0]    q0_q, q0_d;
  logic [ChW-1:0]    val1_q, val2_q;
  logic [ChW-1:0]    level_q, level_d;
  logic [PrdW-1:0]   rcp_prod;
  logic [NumW-1:0]   rem;

  always_comb begin
    sy_d     = FullW'(sat_i) * FullW'(span_i);
    diff_d   = Whole - sy_q;
    x_d      = ScaleW'(val2_q) * ScaleW'(diff_q);
    // drop (frac + 2) low bits: the divisor becomes 3825
    num_d    = x_q[HueFracBits+2 +: NumW];
    rcp_prod = PrdW'(num_d) * PrdW'(h2r_pkg::LVL_RCP);
    q0_d     = rcp_prod[h2r_pkg::LVL_RCP_SHIFT +: ChW];
    // estimate is low by at most one
    rem      = num_q - NumW'(q0_q) * NumW'(h2r_pkg::LVL_DIV);
    level_d  = q0_q + ChW'(rem >= NumW'(h2r_pkg::LVL_DIV));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sy) begin
      sy_q   <= sy_d;
      val1_q <= val_i;
    end
    if (adv_i.diff) begin
      diff_q <= diff_d;
      val2_q <= val1_q;
    end
    if (adv_i.scale) begin
      x_q <= x_d;
    end
    if (adv_i.rcp) begin
      num_q <= num_d;
      q0_q  <= q0_d;
    end
    if (adv_i.fix) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, six-sector scheme in exact integer arithmetic. Hue comes in
// units of 2^-HueFracBits degree, saturation and brightness as 8-bit fractions of 255.
// The block is an 8-stage pipeline: a word enters every cycle while the output side
// keeps taking words. Sustained rate while the output does not stall is one word
// per clock, set by the pipeline itself; every stage is a register with a valid bit,
// so an empty stage fills even while the output is stalled, and the input only
// refuses a word when all eight stages hold one. Stage 1 multiplies the whole-degree
// hue by a reciprocal of 60, stage 2 forms the sector and the in-sector remainder,
// stages 3 to 7 run three identical level units (p, q, t) in parallel, each ending
// in a reciprocal divide with a one-step correction, and stage 8 picks the channels.
// Zero saturation gives gray (all channels equal brightness). Hues at or beyond 360
// degrees take the last (magenta) sector mapping with the usual remainder. No state
// survives between words and there is no start-up sweep after reset.
module hsv_to_rgb_converter #(
  parameter int unsigned HueFracBits = h2r_pkg::HUE_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  h2r_hsv_if.sink      hsv_i,
  h2r_rgb_if.source    rgb_o
);

  localparam int unsigned NStg   = 8;
  localparam int unsigned LvlStg = 5;
  localparam int unsigned SpanW  = HueFracBits + 6;
  localparam int unsigned HueW   = h2r_pkg::HUE_W;
  localparam int unsigned ChW    = h2r_pkg::CH_W;
  localparam int unsigned PrdW   = h2r_pkg::PROD_W;
  localparam int unsigned QuotW  = h2r_pkg::QUOT_W;
  localparam logic [SpanW-1:0] Span   = SpanW'(h2r_pkg::SEC_BASE << HueFracBits);
  localparam logic [SpanW-1:0] LoMask = SpanW'((1 << HueFracBits) - 1);

  typedef struct packed {
    h2r_pkg::h2r_sector_e sec;
    logic                 gray;
    logic [ChW-1:0]       val;
  } side_t;

  // Pipeline control: stage k loads when it is empty or its successor loads
  logic [NStg-1:0] vld_q, vld_d;
  logic [NStg:0]   adv;

  always_comb begin
    adv[NStg] = rgb_o.ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? hsv_i.valid : vld_q[0];
    for (int k = 1; k < NStg; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign hsv_i.ready = adv[0];

  // Stage 1: whole degrees times reciprocal of 60
  logic [HueW-1:0] hue_a_q;
  logic [PrdW-1:0] prod_a_q, prod_a_d;
  logic [ChW-1:0]  sat_a_q, val_a_q;

  assign prod_a_d = PrdW'(hsv_i.hue >> HueFracBits) * PrdW'(h2r_pkg::DIV60_MUL);

  // Stage 2: sector index and remainder inside the sector
  logic [QuotW-1:0]               quot;
  logic [HueW-1:0]                deg, rem_full;
  logic [h2r_pkg::REM60_W-1:0]    rem60;
  logic [SpanW-1:0]               rem_b_d;
  h2r_pkg::h2r_sector_e           sec_b_d;
  logic [SpanW-1:0]               rem_b_q, rcomp_b_q;
  side_t                          side_b_q;
  logic [ChW-1:0]                 sat_b_q;

  always_comb begin
    quot     = prod_a_q[h2r_pkg::DIV60_SHIFT +: QuotW];
    deg      = hue_a_q >> HueFracBits;
    rem_full = deg - HueW'(quot) * HueW'(h2r_pkg::SEC_BASE);
    rem60    = rem_full[h2r_pkg::REM60_W-1:0];
    rem_b_d  = (SpanW'(rem60) << HueFracBits) | (SpanW'(hue_a_q) & LoMask);
    // hues past the last sector keep the last sector's mapping
    if (quot >= QuotW'(h2r_pkg::SEC_5)) begin
      sec_b_d = h2r_pkg::SEC_5;
    end else begin
      sec_b_d = h2r_pkg::h2r_sector_e'(quot[h2r_pkg::SEC_W-1:0]);
    end
  end

  // Stages 3..7: three level units in lockstep, sideband alongside
  h2r_pkg::h2r_lvl_adv_t lvl_adv;
  logic [ChW-1:0]        lvl_p, lvl_q, lvl_t;
  side_t                 side_q [LvlStg];

  assign lvl_adv.sy    = adv[2];
  assign lvl_adv.diff  = adv[3];
  assign lvl_adv.scale = adv[4];
  assign lvl_adv.rcp   = adv[5];
  assign lvl_adv.fix   = adv[6];

  h2r_level #(.HueFracBits(HueFracBits)) u_lvl_p (
    .clk_i   (clk_i),
    .adv_i   (lvl_adv),
    .span_i  (Span),
    .sat_i   (sat_b_q),
    .val_i   (side_b_q.val),
    .level_o (lvl_p)
  );

  h2r_level #(.HueFracBits(HueFracBits)) u_lvl_q (
    .clk_i   (clk_i),
    .adv_i   (lvl_adv),
    .span_i  (rem_b_q),
    .sat_i   (sat_b_q),
    .val_i   (side_b_q.val),
    .level_o (lvl_q)
  );

  h2r_level #(.HueFracBits(HueFracBits)) u_lvl_t (
    .clk_i   (clk_i),
    .adv_i   (lvl_adv),
    .span_i  (rcomp_b_q),
    .sat_i   (sat_b_q),
    .val_i   (side_b_q.val),
    .level_o (lvl_t)
  );

  // Stage 8: channel select, gray override
  logic [ChW-1:0] red_q, green_q, blue_q;
  logic [ChW-1:0] red_d, green_d, blue_d;
  side_t          side_o;

  always_comb begin
    side_o = side_q[LvlStg-1];
    unique case (side_o.sec)
      h2r_pkg::SEC_0: begin
        red_d = side_o.val; green_d = lvl_t;      blue_d = lvl_p;
      end
      h2r_pkg::SEC_1: begin
        red_d = lvl_q;      green_d = side_o.val; blue_d = lvl_p;
      end
      h2r_pkg::SEC_2: begin
        red_d = lvl_p;      green_d = side_o.val; blue_d = lvl_t;
      end
      h2r_pkg::SEC_3: begin
        red_d = lvl_p;      green_d = lvl_q;      blue_d = side_o.val;
      end
      h2r_pkg::SEC_4: begin
        red_d = lvl_t;      green_d = lvl_p;      blue_d = side_o.val;
      end
      default: begin
        red_d = side_o.val; green_d = lvl_p;      blue_d = lvl_q;
      end
    endcase
    if (side_o.gray) begin
      red_d   = side_o.val;
      green_d = side_o.val;
      blue_d  = side_o.val;
    end
  end

  // Payload registers: load on advance, no reset
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      hue_a_q  <= hsv_i.hue;
      prod_a_q <= prod_a_d;
      sat_a_q  <= hsv_i.saturation;
      val_a_q  <= hsv_i.brightness;
    end
    if (adv[1]) begin
      rem_b_q       <= rem_b_d;
      rcomp_b_q     <= Span - rem_b_d;
      sat_b_q       <= sat_a_q;
      side_b_q.sec  <= sec_b_d;
      side_b_q.gray <= (sat_a_q == '0);
      side_b_q.val  <= val_a_q;
    end
    for (int i = 0; i < LvlStg; i++) begin
      if (adv[2+i]) begin
        side_q[i] <= (i == 0) ? side_b_q : side_q[(i == 0) ? 0 : i - 1];
      end
    end
    if (adv[NStg-1]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = vld_q[NStg-1];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

  // Input refuses a word only when every stage is occupied
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> (&vld_q))
    else $error("input stalled with an empty pipeline stage");

  // Levels leaving the units are ordered p <= q, t <= brightness
  a_level_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NStg-2] |-> (lvl_p <= lvl_q && lvl_p <= lvl_t &&
                       lvl_q <= side_q[LvlStg-1].val && lvl_t <= side_q[LvlStg-1].val))
    else $error("channel levels out of order");

endmodule

// ===== bench/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import h2r_pkg::*;

  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned DRAIN_CYCLES = 32;   // pipeline is 8 deep; leave slack

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_color_t;

  // Six-sector conversion in exact integer arithmetic.
  function automatic rgb_color_t hsv_to_rgb(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                            logic [CH_W-1:0] val);
    longint unsigned span, hue_l, sat_l, val_l, rem, scale, lvl_p, lvl_q, lvl_t;
    int unsigned     sector;
    rgb_color_t      color;
    span  = longint'(SEC_BASE) << HUE_FRAC_BITS;
    hue_l = hue;
    sat_l = sat;
    val_l = val;
    // Zero saturation: gray at the brightness level
    if (sat_l == 0) begin
      color = '{red: val, green: val, blue: val};
      return color;
    end
    sector = hue_l / span;
    rem    = hue_l % span;
    scale  = longint'(FULL_SCALE) * span;
    lvl_p  = (val_l * (FULL_SCALE - sat_l)) / FULL_SCALE;
    lvl_q  = (val_l * (scale - sat_l * rem)) / scale;
    lvl_t  = (val_l * (scale - sat_l * (span - rem))) / scale;
    // Sectors 6 and up (hue at or past 360 degrees) fall to the magenta mapping
    case (sector)
      SEC_0:   color = '{red: val,        green: lvl_t[7:0], blue: lvl_p[7:0]};
      SEC_1:   color = '{red: lvl_q[7:0], green: val,        blue: lvl_p[7:0]};
      SEC_2:   color = '{red: lvl_p[7:0], green: val,        blue: lvl_t[7:0]};
      SEC_3:   color = '{red: lvl_p[7:0], green: lvl_q[7:0], blue: val};
      SEC_4:   color = '{red: lvl_t[7:0], green: lvl_p[7:0], blue: val};
      default: color = '{red: val,        green: lvl_p[7:0], blue: lvl_q[7:0]};
    endcase
    return color;
  endfunction

  class rgb_scoreboard;
    rgb_color_t  color_q[$];
    int unsigned n_errors;
    int unsigned n_checked;

    function new();
      n_errors  = 0;
      n_checked = 0;
    endfunction

    function void note_hsv(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                           logic [CH_W-1:0] val);
      color_q.push_back(hsv_to_rgb(hue, sat, val));
    endfunction

    function void check_rgb(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                            logic [CH_W-1:0] blue);
      rgb_color_t want;
      n_checked++;
      if (color_q.size() == 0) begin
        $error("unexpected color word: red %0d green %0d blue %0d", red, green, blue);
        n_errors++;
        return;
      end
      want = color_q.pop_front();
      if (red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, red);
        n_errors++;
      end
      if (green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, green);
        n_errors++;
      end
      if (blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, blue);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  h2r_hsv_if hsv_if ();
  h2r_rgb_if rgb_if ();

  rgb_scoreboard sb = new();

  // Sender-side switch: when set, offer a word on every cycle with no gaps
  bit          send_calm = 1'b0;
  int unsigned n_sent    = 0;

  always #2 clk_i = ~clk_i;

  hsv_to_rgb_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv_if),
    .rgb_o  (rgb_if)
  );

  // Offer one HSV word and hold it until the block takes it. Random idle
  // cycles go in front so gaps land on every pipeline phase. Valid stays
  // high on return; the next call lowers it only if it decides to idle.
  task automatic send_hsv(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                          logic [CH_W-1:0] val);
    while (!send_calm && $urandom_range(99) < IDLE_PCT) begin
      hsv_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    hsv_if.valid      <= 1'b1;
    hsv_if.hue        <= hue;
    hsv_if.saturation <= sat;
    hsv_if.brightness <= val;
    // Ready read right after the edge still shows its pre-edge value
    do @(posedge clk_i); while (!hsv_if.ready);
    sb.note_hsv(hue, sat, val);
    n_sent++;
  endtask

  // Pick a channel level, leaning toward the extremes now and then.
  function automatic logic [CH_W-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 25) return CH_W'(1);
    return CH_W'($urandom_range(255));
  endfunction

  // Mostly in-range hues, sometimes sector borders, sometimes past 360 degrees.
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned roll, span;
    roll = $urandom_range(99);
    span = SEC_BASE << HUE_FRAC_BITS;
    if (roll < 6)  return HUE_W'($urandom_range(2**HUE_W - 1, 6 * span));
    if (roll < 16) return HUE_W'($urandom_range(5) * span + $urandom_range(1) * (span - 1));
    return HUE_W'($urandom_range(6 * span - 1));
  endfunction

  // Receiver: check each taken word, then pick ready for the next cycle.
  // Hold ready low for a long stretch once, so the pipeline fills and the
  // input stalls; run a stretch with ready high throughout as well.
  initial begin : rgb_receiver
    int unsigned hold_left;
    bit          held;
    bit          calm;
    hold_left = 0;
    held      = 1'b0;
    rgb_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rgb_if.valid && rgb_if.ready)
        sb.check_rgb(rgb_if.red, rgb_if.green, rgb_if.blue);
      calm = (sb.n_checked >= 700 && sb.n_checked < 900);
      if (!rst_ni) begin
        rgb_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rgb_if.ready <= 1'b0;
      end else if (!held && sb.n_checked >= 200) begin
        held      = 1'b1;
        hold_left = 80;
        rgb_if.ready <= 1'b0;
      end else begin
        rgb_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : hsv_sender
    int unsigned span;
    span = SEC_BASE << HUE_FRAC_BITS;

    rst_ni            <= 1'b0;
    hsv_if.valid      <= 1'b0;
    hsv_if.hue        <= '0;
    hsv_if.saturation <= '0;
    hsv_if.brightness <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sector borders, gray, full and zero levels, out-of-range hue
    send_hsv('0, '1, '1);
    send_hsv(HUE_W'(span - 1), '1, '1);
    send_hsv(HUE_W'(span), '1, '1);
    send_hsv(HUE_W'(2 * span - 1), 8'd200, 8'd180);
    send_hsv(HUE_W'(2 * span), 8'd128, '1);
    send_hsv(HUE_W'(3 * span + 100), 8'd1, '1);
    send_hsv(HUE_W'(4 * span), '1, 8'd77);
    send_hsv(HUE_W'(5 * span), '1, '1);
    send_hsv(HUE_W'(6 * span - 1), '1, '1);
    send_hsv(HUE_W'(6 * span), '1, '1);
    send_hsv('1, '1, '1);
    send_hsv('1, 8'd1, 8'd254);
    send_hsv(HUE_W'(12345), '0, 8'd99);
    send_hsv('1, '0, '1);
    send_hsv(HUE_W'(span / 2), '1, '0);
    send_hsv(HUE_W'(5 * span + span / 2), 8'd170, 8'd85);
    send_hsv(HUE_W'(16384), 8'h55, 8'hAA);
    send_hsv(HUE_W'(10922), 8'hAA, 8'h55);
    send_hsv(HUE_W'(1), '1, '1);

    // Random: a gap-free stretch, and one pause until the pipeline drains
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      send_calm = (i >= 350 && i < 550);
      if (i == 650) begin
        hsv_if.valid <= 1'b0;
        while (sb.color_q.size() != 0) @(posedge clk_i);
      end
      send_hsv(pick_hue(), pick_level(), pick_level());
    end
    hsv_if.valid <= 1'b0;

    // Drain, then give stray words a chance to show up
    while (sb.color_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.n_errors == 0 && sb.color_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
